>>> rtl/rlc_pkg.sv
package rlc_pkg;

    localparam int NUM_CH = 4;
    localparam int CH_W   = 2;
    localparam int COL_W  = 8;
    localparam int GAIN_W = 10;
    localparam int LEN_W  = 16;
    localparam int Q_W    = 17;
    localparam int MUL_W  = 25;
    localparam int PROD_W = 50;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_COLOUR = 2'd1;
    localparam logic [1:0] CMD_LEVEL  = 2'd2;
    localparam logic [1:0] CMD_ENABLE = 2'd3;

    localparam logic [2:0] REG_RED_GAIN   = 3'd0;
    localparam logic [2:0] REG_GREEN_GAIN = 3'd1;
    localparam logic [2:0] REG_BLUE_GAIN  = 3'd2;
    localparam logic [2:0] REG_WHITE_GAIN = 3'd3;
    localparam logic [2:0] REG_FADE_LEN   = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 10'd256;
    localparam logic [LEN_W-1:0]  LEN_RESET   = 16'd500;
    localparam logic [LEN_W-1:0]  ELAPSED_MAX = 16'hFFFF;
    localparam logic [Q_W-1:0]    ONE_Q16     = 17'h10000;
    localparam logic [MUL_W-1:0]  RECIP_255   = 25'd32897;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [COL_W-1:0] red_in;
        logic [COL_W-1:0] green_in;
        logic [COL_W-1:0] blue_in;
        logic [COL_W-1:0] white_in;
        logic [COL_W-1:0] level_in;
        logic             enable_in;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] red_duty;
        logic [COL_W-1:0] green_duty;
        logic [COL_W-1:0] blue_duty;
        logic [COL_W-1:0] white_duty;
        logic             fading;
    } t_out_item;

    typedef struct packed {
        logic [NUM_CH-1:0][GAIN_W-1:0] gain;
        logic [LEN_W-1:0]              fade_len;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
    } t_div_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN_MUL,
        S_GAIN_WR,
        S_TICK,
        S_DIV,
        S_LVL_MUL,
        S_LVL_ADD,
        S_CH_MUL,
        S_CH_ADD,
        S_CL_MUL,
        S_SCALE,
        S_CH_WR,
        S_OUT
    } t_state;

endpackage

>>> rtl/rlc_apb_regs.sv
module rlc_apb_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rlc_pkg::ADDR_W-1:0] paddr,
    input  logic [rlc_pkg::DATA_W-1:0] pwdata,
    output logic [rlc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output rlc_pkg::t_cfg             o_cfg
);
    import rlc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain     <= {NUM_CH{GAIN_RESET}};
            r_cfg.fade_len <= LEN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RED_GAIN:   r_cfg.gain[0]  <= pwdata[GAIN_W-1:0];
                REG_GREEN_GAIN: r_cfg.gain[1]  <= pwdata[GAIN_W-1:0];
                REG_BLUE_GAIN:  r_cfg.gain[2]  <= pwdata[GAIN_W-1:0];
                REG_WHITE_GAIN: r_cfg.gain[3]  <= pwdata[GAIN_W-1:0];
                REG_FADE_LEN:   r_cfg.fade_len <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RED_GAIN:   prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain[0]};
            REG_GREEN_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain[1]};
            REG_BLUE_GAIN:  prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain[2]};
            REG_WHITE_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain[3]};
            REG_FADE_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.fade_len};
            default:        prdata = '0;
        endcase
    end

endmodule

>>> rtl/rlc_mul.sv
module rlc_mul (
    input  logic                             i_clk,
    input  logic signed [rlc_pkg::MUL_W-1:0]  i_a,
    input  logic signed [rlc_pkg::MUL_W-1:0]  i_b,
    output logic signed [rlc_pkg::PROD_W-1:0] o_prod
);
    import rlc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

endmodule

>>> rtl/rlc_div.sv
module rlc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rlc_pkg::t_div_ctl  i_ctl,
    output rlc_pkg::t_div_stat o_stat
);
    import rlc_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_quot;
    logic [LEN_W:0]   w_shift;
    logic [LEN_W:0]   w_sub;
    logic             w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_len};
    assign w_sub   = w_shift - {1'b0, r_len};

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_ctl.dividend;
            r_len <= i_ctl.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[LEN_W-1:0] : w_shift[LEN_W-1:0];
            r_quot <= {r_quot[LEN_W-2:0], w_ge};
        end
    end

endmodule

>>> rtl/rgbw_led_crossfade.sv
// Brightness and enable commands return to idle; set colour runs a gain multiply and a
// write per channel. A tick first divides a fade fraction when needed (16 steps of the
// restoring divider and one to collect the quotient), then blends level and channels,
// or skips to the output step while outputs are off, and waits for the output register.
// The shared multiplier runs three products per channel in sequence.
// Reset is synchronous and active low; the fade restarts from black at reset.
module rgbw_led_crossfade (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rlc_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rlc_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rlc_pkg::ADDR_W-1:0] paddr,
    input  logic [rlc_pkg::DATA_W-1:0] pwdata,
    output logic [rlc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rlc_pkg::*;

    t_state r_state;
    t_state n_state;

    t_cfg      w_cfg;
    t_div_ctl  w_div_ctl;
    t_div_stat w_div_stat;

    logic [CH_W-1:0]  r_ch;
    logic [LEN_W-1:0] r_e;
    logic             r_fade_active;
    logic             r_on;
    logic [COL_W-1:0] r_shown [NUM_CH];
    logic [COL_W-1:0] r_target [NUM_CH];
    logic [COL_W-1:0] r_duty [NUM_CH];
    logic [COL_W-1:0] r_shown_lvl;
    logic [COL_W-1:0] r_target_lvl;
    t_in_item         r_in;
    logic [Q_W-1:0]   r_p;
    logic [23:0]      r_lvl;
    logic [23:0]      r_col;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic                     w_accept;
    logic                     w_out_free;
    logic [LEN_W-1:0]         w_len;
    logic                     w_commit;
    logic                     w_divide;
    logic [COL_W-1:0]         w_in_ch;
    logic [COL_W-1:0]         w_from;
    logic [COL_W-1:0]         w_to;
    logic [COL_W:0]           w_diff;
    logic signed [25:0]       w_lerp;
    logic [COL_W-1:0]         w_gain_sat;
    logic [COL_W-1:0]         w_duty;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    rlc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rlc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    rlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_stat  (w_div_stat)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_len    = (w_cfg.fade_len == '0) ? 16'd1 : w_cfg.fade_len;
    assign w_commit = r_fade_active && (r_e > w_len);
    assign w_divide = r_fade_active && (r_e < w_len);

    always_comb begin
        unique case (r_ch)
            2'd0:    w_in_ch = r_in.red_in;
            2'd1:    w_in_ch = r_in.green_in;
            2'd2:    w_in_ch = r_in.blue_in;
            default: w_in_ch = r_in.white_in;
        endcase
    end

    assign w_from = (r_state == S_LVL_MUL || r_state == S_LVL_ADD) ? r_shown_lvl : r_shown[r_ch];
    assign w_to   = (r_state == S_LVL_MUL) ? r_target_lvl : r_target[r_ch];
    assign w_diff = {1'b0, w_to} - {1'b0, w_from};
    assign w_lerp = $signed({2'b00, w_from, 16'h0000}) + $signed(w_prod[25:0]);

    assign w_gain_sat = (|w_prod[17:16]) ? 8'hFF : w_prod[15:8];
    assign w_duty     = (|w_prod[PROD_W-1:31]) ? 8'hFF : w_prod[30:23];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.cmd == CMD_COLOUR) begin
                        n_state = S_GAIN_MUL;
                    end else if (i_in_data.cmd == CMD_TICK) begin
                        n_state = S_TICK;
                    end
                end
            end
            S_GAIN_MUL: n_state = S_GAIN_WR;
            S_GAIN_WR:  n_state = (r_ch == 2'd3) ? S_IDLE : S_GAIN_MUL;
            S_TICK: begin
                if (!r_on) begin
                    n_state = S_OUT;
                end else if (w_divide) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_LVL_MUL;
                end
            end
            S_DIV:      n_state = w_div_stat.done ? S_LVL_MUL : S_DIV;
            S_LVL_MUL:  n_state = S_LVL_ADD;
            S_LVL_ADD:  n_state = S_CH_MUL;
            S_CH_MUL:   n_state = S_CH_ADD;
            S_CH_ADD:   n_state = S_CL_MUL;
            S_CL_MUL:   n_state = S_SCALE;
            S_SCALE:    n_state = S_CH_WR;
            S_CH_WR:    n_state = (r_ch == 2'd3) ? S_OUT : S_CH_MUL;
            S_OUT:      n_state = w_out_free ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mul_a            = '0;
        w_mul_b            = '0;
        w_div_ctl.start    = 1'b0;
        w_div_ctl.dividend = r_e;
        w_div_ctl.divisor  = w_len;
        unique case (r_state)
            S_GAIN_MUL: begin
                w_mul_a = $signed({17'b0, w_in_ch});
                w_mul_b = $signed({15'b0, w_cfg.gain[r_ch]});
            end
            S_TICK: begin
                w_div_ctl.start = r_on && w_divide;
            end
            S_LVL_MUL, S_CH_MUL: begin
                w_mul_a = $signed({8'b0, r_p});
                w_mul_b = $signed({{(MUL_W-COL_W-1){w_diff[COL_W]}}, w_diff});
            end
            S_CL_MUL: begin
                w_mul_a = $signed({1'b0, r_col});
                w_mul_b = $signed({1'b0, r_lvl});
            end
            S_SCALE: begin
                w_mul_a = $signed({9'b0, w_prod[47:32]});
                w_mul_b = $signed(RECIP_255);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ch          <= '0;
            r_e           <= '0;
            r_fade_active <= 1'b1;
            r_on          <= 1'b1;
            r_shown_lvl   <= '0;
            r_target_lvl  <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_shown[i]  <= '0;
                r_target[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                unique case (i_in_data.cmd)
                    CMD_TICK: begin
                        if (r_e != ELAPSED_MAX) begin
                            r_e <= r_e + 16'd1;
                        end
                    end
                    CMD_COLOUR: begin
                        r_e           <= '0;
                        r_fade_active <= 1'b1;
                    end
                    CMD_LEVEL: begin
                        r_target_lvl  <= i_in_data.level_in;
                        r_e           <= '0;
                        r_fade_active <= 1'b1;
                    end
                    default: begin
                        r_on <= i_in_data.enable_in;
                    end
                endcase
            end
            if (r_state == S_GAIN_WR) begin
                r_target[r_ch] <= w_gain_sat;
                r_ch           <= r_ch + 2'd1;
            end
            if (r_state == S_CH_WR) begin
                r_ch <= r_ch + 2'd1;
            end
            if (r_state == S_TICK && r_on && w_commit) begin
                r_shown       <= r_target;
                r_shown_lvl   <= r_target_lvl;
                r_fade_active <= 1'b0;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (r_state == S_TICK) begin
            r_p <= ONE_Q16;
        end
        if (r_state == S_DIV && w_div_stat.done) begin
            r_p <= {1'b0, w_div_stat.quot};
        end
        if (r_state == S_LVL_ADD) begin
            r_lvl <= w_lerp[23:0];
        end
        if (r_state == S_CH_ADD) begin
            r_col <= w_lerp[23:0];
        end
        if (r_state == S_CH_WR) begin
            r_duty[r_ch] <= w_duty;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_data.red_duty   <= r_on ? r_duty[0] : '0;
            r_out_data.green_duty <= r_on ? r_duty[1] : '0;
            r_out_data.blue_duty  <= r_on ? r_duty[2] : '0;
            r_out_data.white_duty <= r_on ? r_duty[3] : '0;
            r_out_data.fading     <= r_fade_active;
        end
    end

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_beat_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result beat raised outside the output step");

    a_idle_fade_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fade_active |-> (r_shown_lvl == r_target_lvl))
        else $error("fade inactive while shown level differs from target");

endmodule
